### rtl/jacobi_3d_seven_point_sweep_defines.svh
// Assertion macros shared by the sweep RTL.
`ifndef JACOBI_3D_SEVEN_POINT_SWEEP_DEFINES_SVH
`define JACOBI_3D_SEVEN_POINT_SWEEP_DEFINES_SVH

`ifndef SYNTH

// Condition must hold at every clock edge out of reset.
`define J3D7_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("j3d7 assertion failed");

// Antecedent implies consequent in the same cycle.
`define J3D7_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("j3d7 assertion failed");

// Antecedent implies consequent in the next cycle.
`define J3D7_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("j3d7 assertion failed");

`else

`define J3D7_ASSERT_HOLDS(lbl, expr)
`define J3D7_ASSERT_IMPLIES(lbl, ante, cons)
`define J3D7_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/j3d7_pkg.sv
// Package for the 3D seven-point Jacobi sweep: widths, defaults and payload types.
package j3d7_pkg;

    // Sample and field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int CFG_W        = 8;
    localparam int COORD_W      = 7;

    // Grid side limits and defaults
    localparam int MAX_SIDE_DEF = 128;
    localparam int MIN_SIDE     = 3;
    localparam logic [CFG_W-1:0] GRID_SIDE_RESET = CFG_W'(128);

    // One input transfer
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   grid_start;
    } grid_item_t;

    // One result transfer
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] new_value;
        logic [COORD_W-1:0]     point_x;
        logic [COORD_W-1:0]     point_y;
        logic [COORD_W-1:0]     point_z;
        logic                   last_point;
    } update_item_t;

endpackage

### rtl/jacobi_3d_seven_point_sweep.sv
// Streaming 3D seven-point Jacobi sweep over a cubic grid fed in raster order.
`include "jacobi_3d_seven_point_sweep_defines.svh"

// One grid sample is taken per clock cycle while the input is not stalled, with
// no gaps at grid or plane boundaries. The sample window lives in two
// single-write memories of 2*MAX_SIDE^2+9 entries: one holds each sample paired
// with the sample two transfers older (so one read yields both x neighbors), the
// other holds the sample alone; each is read at two addresses per cycle. A
// point's result passes through the six-stage pipe once its upper neighbor is
// taken and enters an 8-entry result queue; input is stalled only while that
// queue plus the results in flight total 8. The window needs no clearing pass
// after reset; boundary points produce no transfer.
module jacobi_3d_seven_point_sweep #(
    parameter int MAX_SIDE = j3d7_pkg::MAX_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            side_we,
    input  logic [j3d7_pkg::CFG_W-1:0]      side_wdata,
    input  logic                            grid_valid,
    output logic                            grid_stall,
    input  j3d7_pkg::grid_item_t            grid_data,
    output logic                            update_valid,
    input  logic                            update_stall,
    output j3d7_pkg::update_item_t          update_data
);
    import j3d7_pkg::*;

    // Derived sizes
    localparam int CW        = $clog2(MAX_SIDE);
    localparam int NW        = $clog2(MAX_SIDE + 1);
    localparam int SW        = (NW > CFG_W) ? NW : CFG_W;
    localparam int GUARD     = 8;
    localparam int WIN_DEPTH = 2 * MAX_SIDE * MAX_SIDE + 1 + GUARD;
    localparam int AW        = $clog2(WIN_DEPTH);
    localparam int SB        = SAMPLE_BITS;
    localparam int SUMW      = SB + 3;
    localparam int RSH       = SUMW + 2;
    localparam int RECIP     = ((1 << RSH) + 5) / 6;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int QDEPTH    = 8;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } tag_t;

    // Address of the entry k transfers back from wp, modulo the window depth
    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
                                                input logic [AW-1:0] k);
        logic [AW:0] diff;
        logic [AW:0] wrapped;
        diff    = {1'b0, wp} - {1'b0, k};
        wrapped = diff + (AW+1)'(WIN_DEPTH);
        return diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];
    endfunction

    // Control state
    logic [CFG_W-1:0]  side_reg;
    logic [CW-1:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [CW-1:0]     pos_x_next, pos_y_next, pos_z_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [QCW-1:0]    occ_reg, occ_next;
    logic [QCW-1:0]    q_cnt_reg, q_cnt_next;
    logic [QAW-1:0]    q_wr_reg, q_rd_reg;
    logic              st1_valid_reg, st2_valid_reg, st3_valid_reg;
    logic              st4_valid_reg, st5_valid_reg, st6_valid_reg;

    // Payload state
    logic [SB-1:0]     prev1_reg, prev2_reg;
    logic [SB-1:0]     st1_cur_reg, st2_cur_reg, st3_cur_reg, st4_cur_reg, st5_cur_reg;
    logic [AW-1:0]     st1_wp_reg, st2_wp_reg, st3_wp_reg;
    logic [NW-1:0]     st1_n_reg, st2_n_reg;
    logic [AW-1:0]     st2_plane_reg;
    logic [AW-1:0]     st3_k_2p_reg, st3_k_ppn_reg, st3_k_pm1_reg, st3_k_pmn_reg;
    logic [AW-1:0]     st4_a_2p_reg, st4_a_ppn_reg, st4_a_pm1_reg, st4_a_pmn_reg;
    logic [2*SB-1:0]   st5_rd_pm1_reg, st5_rd_pmn_reg;
    logic [SB-1:0]     st5_rd_2p_reg, st5_rd_ppn_reg;
    logic [SUMW-1:0]   st6_sum_reg;
    tag_t              st1_tag_reg, st2_tag_reg, st3_tag_reg;
    tag_t              st4_tag_reg, st5_tag_reg, st6_tag_reg;
    update_item_t      q_mem_reg [QDEPTH];

    // Window memories
    logic [2*SB-1:0]   mem_a [WIN_DEPTH];
    logic [SB-1:0]     mem_b [WIN_DEPTH];

    // Combinational signals
    logic [SW-1:0]     side_ext;
    logic [NW-1:0]     n_cur;
    logic [NW-1:0]     px, py, pz;
    logic              accept, emit, push, pop;
    tag_t              tag_cur;
    logic [SUMW-1:0]   sum_raw;
    logic [SUMW+RW-1:0] prod;
    update_item_t      q_in;

    // Handshake
    assign accept       = grid_valid && !grid_stall;
    assign grid_stall   = (occ_reg == QCW'(QDEPTH));
    assign push         = st6_valid_reg;
    assign pop          = update_valid && !update_stall;
    assign update_valid = (q_cnt_reg != '0);
    assign update_data  = q_mem_reg[q_rd_reg];

    // Side clamp
    assign side_ext = SW'(side_reg);
    always_comb
    begin
        if (side_ext < SW'(MIN_SIDE))
            n_cur = NW'(MIN_SIDE);
        else if (side_ext > SW'(MAX_SIDE))
            n_cur = NW'(MAX_SIDE);
        else
            n_cur = NW'(side_ext);
    end

    // Effective position: grid_start restarts at the origin
    assign px = grid_data.grid_start ? '0 : NW'(pos_x_reg);
    assign py = grid_data.grid_start ? '0 : NW'(pos_y_reg);
    assign pz = grid_data.grid_start ? '0 : NW'(pos_z_reg);

    // Current sample is the upper neighbor of (px, py, pz-1)
    assign emit = (px >= NW'(1)) && (px <= n_cur - NW'(2)) &&
                  (py >= NW'(1)) && (py <= n_cur - NW'(2)) &&
                  (pz >= NW'(2)) && (pz <= n_cur - NW'(1));

    always_comb
    begin
        tag_cur.x    = COORD_W'(px);
        tag_cur.y    = COORD_W'(py);
        tag_cur.z    = COORD_W'(pz - NW'(1));
        tag_cur.last = (px == n_cur - NW'(2)) && (py == n_cur - NW'(2)) &&
                       (pz == n_cur - NW'(1));
    end

    // Raster counters, wrapping at the current side
    always_comb
    begin
        pos_x_next = CW'(px);
        pos_y_next = CW'(py);
        pos_z_next = CW'(pz);
        if (NW'(px + NW'(1)) >= n_cur)
        begin
            pos_x_next = '0;
            if (NW'(py + NW'(1)) >= n_cur)
            begin
                pos_y_next = '0;
                if (NW'(pz + NW'(1)) >= n_cur)
                    pos_z_next = '0;
                else
                    pos_z_next = CW'(pz + NW'(1));
            end
            else
            begin
                pos_y_next = CW'(py + NW'(1));
            end
        end
        else
        begin
            pos_x_next = CW'(px + NW'(1));
        end
    end

    assign wp_next = (wp_reg == AW'(WIN_DEPTH - 1)) ? '0 : wp_reg + AW'(1);

    // Occupancy of queue plus results in flight
    assign occ_next   = occ_reg + QCW'(accept && emit) - QCW'(pop);
    assign q_cnt_next = q_cnt_reg + QCW'(push) - QCW'(pop);

    // Six-neighbor sum and divide by six through a reciprocal
    assign sum_raw = SUMW'(st5_cur_reg) + SUMW'(st5_rd_2p_reg) + SUMW'(st5_rd_ppn_reg) +
                     SUMW'(st5_rd_pm1_reg[2*SB-1:SB]) + SUMW'(st5_rd_pm1_reg[SB-1:0]) +
                     SUMW'(st5_rd_pmn_reg[2*SB-1:SB]);
    assign prod    = SUMW'(st6_sum_reg) * RW'(RECIP);

    always_comb
    begin
        q_in.new_value  = SB'(prod >> RSH);
        q_in.point_x    = st6_tag_reg.x;
        q_in.point_y    = st6_tag_reg.y;
        q_in.point_z    = st6_tag_reg.z;
        q_in.last_point = st6_tag_reg.last;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg      <= GRID_SIDE_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            wp_reg        <= '0;
            occ_reg       <= '0;
            q_cnt_reg     <= '0;
            q_wr_reg      <= '0;
            q_rd_reg      <= '0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
        end
        else
        begin
            if (side_we)
                side_reg <= side_wdata;
            if (accept)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                pos_z_reg <= pos_z_next;
                wp_reg    <= wp_next;
            end
            occ_reg       <= occ_next;
            q_cnt_reg     <= q_cnt_next;
            if (push)
                q_wr_reg <= q_wr_reg + QAW'(1);
            if (pop)
                q_rd_reg <= q_rd_reg + QAW'(1);
            st1_valid_reg <= accept && emit;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
            st6_valid_reg <= st5_valid_reg;
        end
    end

    // Pipeline payload: plane size, offsets, addresses, sum
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev1_reg   <= grid_data.sample;
            prev2_reg   <= prev1_reg;
            st1_cur_reg <= grid_data.sample;
            st1_wp_reg  <= wp_reg;
            st1_n_reg   <= n_cur;
            st1_tag_reg <= tag_cur;
        end
        st2_cur_reg   <= st1_cur_reg;
        st2_wp_reg    <= st1_wp_reg;
        st2_n_reg     <= st1_n_reg;
        st2_plane_reg <= AW'(st1_n_reg) * AW'(st1_n_reg);
        st2_tag_reg   <= st1_tag_reg;

        st3_cur_reg   <= st2_cur_reg;
        st3_wp_reg    <= st2_wp_reg;
        st3_k_2p_reg  <= AW'({st2_plane_reg, 1'b0});
        st3_k_ppn_reg <= st2_plane_reg + AW'(st2_n_reg);
        st3_k_pm1_reg <= st2_plane_reg - AW'(1);
        st3_k_pmn_reg <= st2_plane_reg - AW'(st2_n_reg);
        st3_tag_reg   <= st2_tag_reg;

        st4_cur_reg   <= st3_cur_reg;
        st4_a_2p_reg  <= back_addr(st3_wp_reg, st3_k_2p_reg);
        st4_a_ppn_reg <= back_addr(st3_wp_reg, st3_k_ppn_reg);
        st4_a_pm1_reg <= back_addr(st3_wp_reg, st3_k_pm1_reg);
        st4_a_pmn_reg <= back_addr(st3_wp_reg, st3_k_pmn_reg);
        st4_tag_reg   <= st3_tag_reg;

        st5_cur_reg   <= st4_cur_reg;
        st5_tag_reg   <= st4_tag_reg;

        st6_sum_reg   <= sum_raw + SUMW'(3);
        st6_tag_reg   <= st5_tag_reg;

        if (push)
            q_mem_reg[q_wr_reg] <= q_in;
    end

    // Window memories: write newest sample, read four taps.
    // Every tap is at least six transfers back, so a read never meets a
    // write still in flight; the guard entries keep the oldest tap intact
    // while later samples are written during the read latency.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_a[wp_reg] <= {grid_data.sample, prev2_reg};
            mem_b[wp_reg] <= grid_data.sample;
        end
        st5_rd_pm1_reg <= mem_a[st4_a_pm1_reg];
        st5_rd_pmn_reg <= mem_a[st4_a_pmn_reg];
        st5_rd_2p_reg  <= mem_b[st4_a_2p_reg];
        st5_rd_ppn_reg <= mem_b[st4_a_ppn_reg];
    end

    // Checks
    `J3D7_ASSERT_HOLDS(a_occ_matches, int'(occ_reg) == int'(q_cnt_reg) + $countones({st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg, st5_valid_reg, st6_valid_reg}))
    `J3D7_ASSERT_IMPLIES(a_no_queue_overflow, push, q_cnt_reg != QCW'(QDEPTH))
    `J3D7_ASSERT_IMPLIES(a_pipe_chain, st6_valid_reg, $past(st1_valid_reg, 5))
    `J3D7_ASSERT_NEXT(a_emit_enters, !accept, !st1_valid_reg)

endmodule

### bench/jacobi_3d_seven_point_sweep_tb.sv
// Self-checking bench for the 3D seven-point Jacobi sweep: random streams against a local predictor.
module jacobi_3d_seven_point_sweep_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import j3d7_pkg::*;

    localparam int RING_DEPTH   = 2 * MAX_SIDE_DEF * MAX_SIDE_DEF + 1;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef enum {FILL_RANDOM, FILL_FULL, FILL_ZERO} fill_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 side_we;
    logic [CFG_W-1:0]     side_wdata;
    logic                 grid_valid = 1'b0;
    logic                 grid_stall;
    grid_item_t           grid_data = '0;
    logic                 update_valid;
    logic                 update_stall = 1'b0;
    update_item_t         update_data;

    // Sample stream waiting to go out, and point updates still owed by the block
    grid_item_t           grid_feed[$];
    update_item_t         pending_updates[$];

    // Local copy of the sweep state
    logic [CFG_W-1:0]     side_reg;
    logic [SAMPLE_BITS-1:0] sample_ring[RING_DEPTH];
    int                   ring_wr = 0;
    int                   at_x = 0;
    int                   at_y = 0;
    int                   at_z = 0;

    // Traffic shaping
    bit                   calm;
    bit                   pressure_phase;
    logic                 long_hold;
    int                   hold_left;
    bit                   hold_used;
    int                   feed_gap;
    int                   stall_left;

    int                   fault_count = 0;
    int                   cycle_count = 0;

    jacobi_3d_seven_point_sweep dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .side_we      (side_we),
        .side_wdata   (side_wdata),
        .grid_valid   (grid_valid),
        .grid_stall   (grid_stall),
        .grid_data    (grid_data),
        .update_valid (update_valid),
        .update_stall (update_stall),
        .update_data  (update_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Effective grid side after clamping to the supported range
    function automatic int side_eff(input logic [CFG_W-1:0] value);
        int n;
        n = value;
        if (n < MIN_SIDE)
            n = MIN_SIDE;
        if (n > MAX_SIDE_DEF)
            n = MAX_SIDE_DEF;
        return n;
    endfunction

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 30);
    endfunction

    // Sample taken k transfers before the next write slot
    function automatic logic [SAMPLE_BITS-1:0] ring_tap(input int k);
        return sample_ring[(ring_wr + RING_DEPTH - k) % RING_DEPTH];
    endfunction

    // Advance the sweep by one sample; owe an update when an interior point completes
    task automatic sweep_predict(input grid_item_t item);
        int n;
        int plane;
        int sum;
        update_item_t upd;
        n = side_eff(side_reg);
        plane = n * n;
        if (item.grid_start)
        begin
            at_x = 0;
            at_y = 0;
            at_z = 0;
        end
        if (at_x >= 1 && at_x <= n - 2 && at_y >= 1 && at_y <= n - 2 &&
            at_z >= 2 && at_z <= n - 1)
        begin
            sum = item.sample + ring_tap(2 * plane) + ring_tap(plane + 1) +
                  ring_tap(plane - 1) + ring_tap(plane - n) + ring_tap(plane + n);
            upd.new_value  = SAMPLE_BITS'((sum + 3) / 6);
            upd.point_x    = COORD_W'(at_x);
            upd.point_y    = COORD_W'(at_y);
            upd.point_z    = COORD_W'(at_z - 1);
            upd.last_point = (at_x == n - 2 && at_y == n - 2 && at_z - 1 == n - 2);
            pending_updates.push_back(upd);
        end
        sample_ring[ring_wr] = item.sample;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        // raster advance; counters beyond a shrunk side wrap on the next step
        if (at_x + 1 >= n)
        begin
            at_x = 0;
            if (at_y + 1 >= n)
            begin
                at_y = 0;
                at_z = (at_z + 1 >= n) ? 0 : at_z + 1;
            end
            else
                at_y++;
        end
        else
            at_x++;
    endtask

    // Compare one update transfer with the oldest owed update
    task automatic check_update(input update_item_t got);
        update_item_t want;
        if (pending_updates.size() == 0)
        begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
                $display("unexpected update: value %h x %0d y %0d z %0d last %b",
                         got.new_value, got.point_x, got.point_y, got.point_z,
                         got.last_point);
        end
        else
        begin
            want = pending_updates.pop_front();
            if (got.new_value !== want.new_value || got.point_x !== want.point_x ||
                got.point_y !== want.point_y || got.point_z !== want.point_z ||
                got.last_point !== want.last_point)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("update mismatch: want %h (%0d,%0d,%0d) last %b, got %h (%0d,%0d,%0d) last %b",
                             want.new_value, want.point_x, want.point_y, want.point_z,
                             want.last_point, got.new_value, got.point_x, got.point_y,
                             got.point_z, got.last_point);
            end
        end
    endtask

    // Write the side register; the block is idle here
    task automatic write_side(input logic [CFG_W-1:0] value);
        @(posedge clk);
        side_we    <= 1'b1;
        side_wdata <= value;
        side_reg   <= value;
        @(posedge clk);
        side_we    <= 1'b0;
    endtask

    // Append samples to the outgoing stream
    task automatic queue_samples(input int count, input bit lead_start, input fill_t fill,
                                 input int start_permille);
        grid_item_t item;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            case (fill)
                FILL_FULL: item.sample = '1;
                FILL_ZERO: item.sample = '0;
                default:
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        item.sample = '0;
                    else if (pick == 1)
                        item.sample = '1;
                    else
                        item.sample = SAMPLE_BITS'($urandom_range(0, 65535));
                end
            endcase
            item.grid_start = (i == 0 && lead_start) ||
                              (int'($urandom_range(0, 999)) < start_permille);
            grid_feed.push_back(item);
        end
    endtask

    // Wait until every sample is taken and every update has come back
    task automatic settle();
        do
            @(negedge clk);
        while (grid_feed.size() != 0 || grid_valid || pending_updates.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            grid_valid <= 1'b0;
            feed_gap = 0;
        end
        else
        begin
            if (grid_valid && !grid_stall)
                sweep_predict(grid_data);
            if (!grid_valid || !grid_stall)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    grid_valid <= 1'b0;
                end
                else if (grid_feed.size() != 0)
                begin
                    grid_data  <= grid_feed.pop_front();
                    grid_valid <= 1'b1;
                    feed_gap = calm ? 0 : pick_pause();
                end
                else
                    grid_valid <= 1'b0;
            end
        end
    end

    // Update monitor with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            update_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (update_valid && !update_stall)
                check_update(update_data);
            if (stall_left > 0)
            begin
                stall_left--;
                update_stall <= 1'b1;
            end
            else
            begin
                stall_left = calm ? 0 : pick_pause();
                update_stall <= long_hold;
            end
        end
    end

    // One long receiver hold-off during the dense phase, so the block backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end
        else
        begin
            if (hold_left > 0)
                hold_left--;
            else if (pressure_phase && !hold_used)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            long_hold <= (hold_left > 0);
        end
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int n;
        int grids;
        int count;
        int small_items;
        logic [CFG_W-1:0] side_value;

        rst_n          = 1'b0;
        side_we        = 1'b0;
        side_wdata     = '0;
        side_reg       = GRID_SIDE_RESET;
        calm           = 1'b0;
        pressure_phase = 1'b0;
        small_items    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest grid (side below range clamps to 3): full scale, then zeros
        // with no start marker so the counters wrap into the next grid
        write_side(8'd0);
        @(negedge clk);
        queue_samples(27, 1'b1, FILL_FULL, 0);
        queue_samples(27, 1'b0, FILL_ZERO, 0);
        settle();

        // Dense grid with a long receiver hold-off to fill the result queue
        write_side(8'd6);
        @(negedge clk);
        calm = 1'b1;
        pressure_phase = 1'b1;
        queue_samples(216, 1'b1, FILL_RANDOM, 0);
        settle();
        calm = 1'b0;

        // Small sides: mostly whole grids, some streams with stray start markers
        while (small_items < 250)
        begin
            side_value = CFG_W'($urandom_range(0, 7));
            n = side_eff(side_value);
            write_side(side_value);
            @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                grids = (n > 6) ? 1 : $urandom_range(1, 3);
                for (int g = 0; g < grids; g++)
                    queue_samples(n * n * n, g == 0 || $urandom_range(0, 1) == 1,
                                  FILL_RANDOM, 0);
                small_items += grids * n * n * n;
            end
            else
            begin
                count = $urandom_range(20, 250);
                queue_samples(count, 1'b1, FILL_RANDOM, 15);
                small_items += count;
            end
            settle();
        end

        // Largest side (over-range value clamps): one row and a bit, so x
        // wraps at the clamped side
        write_side(8'd200);
        @(negedge clk);
        calm = 1'b0;
        queue_samples(MAX_SIDE_DEF + 2, 1'b1, FILL_RANDOM, 0);
        settle();

        // Side changes in mid-grid: shrink, grow to the top value, shrink again
        write_side(8'd5);
        @(negedge clk);
        queue_samples(150, 1'b0, FILL_RANDOM, 0);
        settle();
        write_side(8'd255);
        @(negedge clk);
        queue_samples(200, 1'b0, FILL_RANDOM, 0);
        settle();
        write_side(8'd4);
        @(negedge clk);
        queue_samples(100, 1'b0, FILL_RANDOM, 10);
        settle();

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
